// ----- hw/rtl/timestamp_fifo_with_drop_stats_top_macros.svh -----
// Assertion helpers for the timestamp queue. Each one expects clk and arst_n in scope.
`ifndef TIMESTAMP_FIFO_WITH_DROP_STATS_TOP_MACROS_SVH
`define TIMESTAMP_FIFO_WITH_DROP_STATS_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TFDS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TFDS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/tfds_pkg.sv -----
package tfds_pkg;

	localparam int DEPTH     = 32;
	localparam int TIME_BITS = 32;

	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int NOW_W   = 32;
	localparam int WAIT_W  = 32;
	localparam int OCC_W   = 6;
	localparam int TOTAL_W = 32;
	localparam int DELAY_W = 48;

	localparam logic [DELAY_W-1:0] DELAY_MAX = '1;

	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [TIME_BITS-1:0] stamp_t;

	typedef enum logic {
		CMD_ARRIVE  = 1'b0,
		CMD_SERVICE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		STS_ACCEPTED = 2'd0,
		STS_DROPPED  = 2'd1,
		STS_REMOVED  = 2'd2,
		STS_EMPTY    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_READ = 2'b10
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic arrive;
		logic empty_svc;
		logic start_read;
		logic finish_read;
		logic out_take;
	} ctrl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic empty;
		logic out_full;
	} stat_t;

	function automatic idx_t next_idx(idx_t i);
		return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

endpackage

// ----- hw/rtl/tfds_ram.sv -----
module tfds_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hw/rtl/tfds_ctrl.sv -----
module tfds_ctrl import tfds_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  logic  command,
	input  logic  out_stall,
	input  stat_t stat,
	output ctrl_t ctrl
);

	state_t state_q;
	logic   in_ready;
	logic   accept;
	logic   is_service;

	// A new word is taken only when the output register is free or drains this cycle.
	assign in_ready   = (state_q == S_IDLE) && (!stat.out_full || !out_stall);
	assign in_stall   = !in_ready;
	assign accept     = in_valid && in_ready;
	assign is_service = (command == CMD_SERVICE);

	always_comb begin
		ctrl.arrive      = accept && !is_service;
		ctrl.empty_svc   = accept && is_service && stat.empty;
		ctrl.start_read  = accept && is_service && !stat.empty;
		ctrl.finish_read = (state_q == S_READ);
		ctrl.out_take    = stat.out_full && !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (ctrl.start_read) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- hw/rtl/tfds_datapath.sv -----
module tfds_datapath import tfds_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  ctrl_t               ctrl,
	output stat_t               stat,
	input  logic [NOW_W-1:0]    now,
	output logic [1:0]          status,
	output logic [WAIT_W-1:0]   wait_time,
	output logic [OCC_W-1:0]    occupancy,
	output logic [TOTAL_W-1:0]  accepted_count,
	output logic [TOTAL_W-1:0]  dropped_count,
	output logic [DELAY_W-1:0]  delay_total,
	output logic                out_valid
);

	idx_t                head_q;
	idx_t                tail_q;
	cnt_t                count_q;
	logic [TOTAL_W-1:0]  acc_q;
	logic [TOTAL_W-1:0]  drop_q;
	logic [DELAY_W-1:0]  delay_q;
	logic                out_valid_q;
	stamp_t              now_s1;
	stamp_t              rd_stamp;

	status_t             status_q;
	logic [WAIT_W-1:0]   wait_q;
	logic [OCC_W-1:0]    occ_q;

	logic                full;
	logic                empty;
	logic                write_en;
	stamp_t              wait_v;
	logic [DELAY_W:0]    sum_w;
	logic [DELAY_W-1:0]  delay_next;
	logic                load_out;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign write_en = ctrl.arrive && !full;
	assign load_out = ctrl.arrive || ctrl.empty_svc || ctrl.finish_read;

	// The stamp read in the previous cycle meets the time latched with the service word.
	assign wait_v     = now_s1 - rd_stamp;
	assign sum_w      = {1'b0, delay_q} + (DELAY_W + 1)'(wait_v);
	assign delay_next = sum_w[DELAY_W] ? DELAY_MAX : sum_w[DELAY_W-1:0];

	assign stat.empty    = empty;
	assign stat.out_full = out_valid_q;

	tfds_ram #(
		.WIDTH(TIME_BITS),
		.DEPTH(DEPTH)
	) u_stamp_ram (
		.clk  (clk),
		.we   (write_en),
		.waddr(tail_q),
		.wdata(TIME_BITS'(now)),
		.re   (ctrl.start_read),
		.raddr(head_q),
		.rdata(rd_stamp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			acc_q       <= '0;
			drop_q      <= '0;
			delay_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.arrive) begin
				if (full) begin
					drop_q <= drop_q + 1'b1;
				end else begin
					tail_q  <= next_idx(tail_q);
					count_q <= count_q + 1'b1;
					acc_q   <= acc_q + 1'b1;
				end
			end
			if (ctrl.finish_read) begin
				head_q  <= next_idx(head_q);
				count_q <= count_q - 1'b1;
				delay_q <= delay_next;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (ctrl.out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start_read) begin
			now_s1 <= TIME_BITS'(now);
		end
		if (ctrl.arrive) begin
			status_q <= full ? STS_DROPPED : STS_ACCEPTED;
			wait_q   <= '0;
			occ_q    <= full ? OCC_W'(count_q) : OCC_W'(count_q + 1'b1);
		end else if (ctrl.empty_svc) begin
			status_q <= STS_EMPTY;
			wait_q   <= '0;
			occ_q    <= OCC_W'(count_q);
		end else if (ctrl.finish_read) begin
			status_q <= STS_REMOVED;
			wait_q   <= WAIT_W'(wait_v);
			occ_q    <= OCC_W'(count_q - 1'b1);
		end
	end

	// Totals are shown straight from the state; no word is taken while one is in flight.
	assign status         = status_q;
	assign wait_time      = wait_q;
	assign occupancy      = occ_q;
	assign accepted_count = acc_q;
	assign dropped_count  = drop_q;
	assign delay_total    = delay_q;
	assign out_valid      = out_valid_q;

endmodule

// ----- hw/rtl/timestamp_fifo_with_drop_stats_top.sv -----
// An arrival, or a service on an empty queue, gives its result in the cycle after accept.
// A service that removes an entry gives its result from the result registers, loaded in the
// read state after the registered read of the stamp memory.
// One arrival word per cycle unless out_stall holds a full output; none while a stamp is read.
// Reset (arst_n low, asynchronous) clears pointers, entry count, totals and output valid;
// the stamp memory is not cleared and needs no clearing pass.
`include "timestamp_fifo_with_drop_stats_top_macros.svh"

module timestamp_fifo_with_drop_stats_top import tfds_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                command,
	input  logic [NOW_W-1:0]    now,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          status,
	output logic [WAIT_W-1:0]   wait_time,
	output logic [OCC_W-1:0]    occupancy,
	output logic [TOTAL_W-1:0]  accepted_count,
	output logic [TOTAL_W-1:0]  dropped_count,
	output logic [DELAY_W-1:0]  delay_total
);

	ctrl_t ctrl;
	stat_t stat;
	logic  out_drop;
	logic  out_acc;

	tfds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.command  (command),
		.out_stall(out_stall),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	tfds_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.stat          (stat),
		.now           (now),
		.status        (status),
		.wait_time     (wait_time),
		.occupancy     (occupancy),
		.accepted_count(accepted_count),
		.dropped_count (dropped_count),
		.delay_total   (delay_total),
		.out_valid     (out_valid)
	);

	assign out_drop = out_valid && (status == STS_DROPPED);
	assign out_acc  = out_valid && (status == STS_ACCEPTED);

	`TFDS_ASSERT_SAME(a_stall_back, out_valid && out_stall, in_stall, "input taken while blocked")
	`TFDS_ASSERT_NEXT(a_read_done, ctrl.start_read, ctrl.finish_read, "stamp read not completed")
	`TFDS_ASSERT_SAME(a_drop_full, out_drop, occupancy == OCC_W'(DEPTH), "drop below full")
	`TFDS_ASSERT_SAME(a_acc_nonempty, out_acc, occupancy != '0, "accept with empty queue")

endmodule
